// File: hw/rtl/usri_pkg.sv
// Shared types and constants of the unit sphere ray intersection pipeline.
package usri_pkg;

    // Coordinate and product widths
    localparam int COORD_W   = 24;
    localparam int PROD_W    = 48;
    // Discriminant width and square root width
    localparam int Q_W       = 100;
    localparam int SQRT_BITS = 50;
    // Numerator width, divider remainder width, quotient bits
    localparam int NUM_W     = 51;
    localparam int REM_W     = 80;
    localparam int DIV_BITS  = 31;
    localparam int FRAC_W    = 16;
    localparam int T_W       = 32;
    localparam logic [T_W-1:0] T_SAT = 32'h7FFF_FFFF;

    // Hit kinds
    localparam logic KIND_SURFACE = 1'b0;
    localparam logic KIND_SHADOW  = 1'b1;

    // Ray data carried along the square root chain
    typedef struct packed {
        logic [PROD_W-1:0]        a;
        logic signed [PROD_W:0]   h;
        logic                     shadow;
        logic                     dead;
    } usri_ray_t;

    // Result control carried along the divider chain
    typedef struct packed {
        logic [1:0] cnt;
        logic       kind;
        logic       sat1;
        logic       sat2;
    } usri_hit_t;

endpackage

// File: hw/rtl/usri_front.sv
// Front end: products, quadratic coefficients and the quarter discriminant.
module usri_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [143:0]                  in_data,
    input  logic                          in_shadow,
    output logic                          out_valid,
    output logic [usri_pkg::Q_W-1:0]      out_q,
    output usri_pkg::usri_ray_t           out_ray
);
    import usri_pkg::*;

    // Stage 1: input registers
    logic v1_reg;
    logic signed [COORD_W-1:0] sx_reg, sy_reg, sz_reg, dx_reg, dy_reg, dz_reg;
    logic sh1_reg;
    // Stage 2: products
    logic v2_reg, sh2_reg;
    logic signed [PROD_W-1:0] pdd_x_reg, pdd_y_reg, pdd_z_reg;
    logic signed [PROD_W-1:0] pds_x_reg, pds_y_reg, pds_z_reg;
    logic signed [PROD_W-1:0] pss_x_reg, pss_y_reg, pss_z_reg;
    // Stage 3: coefficients
    logic v3_reg, sh3_reg;
    logic [PROD_W-1:0] a3_reg;
    logic signed [PROD_W:0] h3_reg, c3_reg;
    logic signed [PROD_W+1:0] h3_next, c3_next, a3_sum;
    // Stage 4: partial products
    logic v4_reg, sh4_reg, cneg4_reg, zero4_reg;
    logic [PROD_W-1:0] a4_reg;
    logic signed [PROD_W:0] h4_reg;
    logic [PROD_W-1:0] habs, cabs;
    logic [PROD_W-1:0] hll_reg, hlh_reg, hhh_reg;
    logic [PROD_W-1:0] all_reg, alh_reg, ahl_reg, ahh_reg;
    // Stage 5: full squares and products
    logic v5_reg, sh5_reg, cneg5_reg, zero5_reg;
    logic [PROD_W-1:0] a5_reg;
    logic signed [PROD_W:0] h5_reg;
    logic [95:0] hh5_reg, ac5_reg;
    // Stage 6: discriminant
    logic v6_reg;
    logic [Q_W-1:0] q6_reg;
    usri_ray_t ray6_reg;
    logic [96:0] q_next;

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // Sum the products into a, b/2 and c
    assign a3_sum  = 50'(pdd_x_reg) + 50'(pdd_y_reg) + 50'(pdd_z_reg);
    assign h3_next = 50'(pds_x_reg) + 50'(pds_y_reg) + 50'(pds_z_reg);
    assign c3_next = 50'(pss_x_reg) + 50'(pss_y_reg) + 50'(pss_z_reg)
                   - 50'sh1_0000_0000;

    // Magnitudes for the wide squares
    assign habs = h3_reg[PROD_W] ? PROD_W'(-h3_reg) : PROD_W'(h3_reg);
    assign cabs = c3_reg[PROD_W] ? PROD_W'(-c3_reg) : PROD_W'(c3_reg);

    // Combine h*h - a*c by the sign of c
    assign q_next = cneg5_reg ? (97'(hh5_reg) + 97'(ac5_reg))
                              : (97'(hh5_reg) - 97'(ac5_reg));

    // Payload stages
    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg  <= in_data[23:0];
            sy_reg  <= in_data[47:24];
            sz_reg  <= in_data[71:48];
            dx_reg  <= in_data[95:72];
            dy_reg  <= in_data[119:96];
            dz_reg  <= in_data[143:120];
            sh1_reg <= in_shadow;

            pdd_x_reg <= dx_reg * dx_reg;
            pdd_y_reg <= dy_reg * dy_reg;
            pdd_z_reg <= dz_reg * dz_reg;
            pds_x_reg <= dx_reg * sx_reg;
            pds_y_reg <= dy_reg * sy_reg;
            pds_z_reg <= dz_reg * sz_reg;
            pss_x_reg <= sx_reg * sx_reg;
            pss_y_reg <= sy_reg * sy_reg;
            pss_z_reg <= sz_reg * sz_reg;
            sh2_reg   <= sh1_reg;

            a3_reg  <= a3_sum[PROD_W-1:0];
            h3_reg  <= h3_next[PROD_W:0];
            c3_reg  <= c3_next[PROD_W:0];
            sh3_reg <= sh2_reg;

            hll_reg   <= habs[23:0] * habs[23:0];
            hlh_reg   <= habs[23:0] * habs[47:24];
            hhh_reg   <= habs[47:24] * habs[47:24];
            all_reg   <= a3_reg[23:0] * cabs[23:0];
            alh_reg   <= a3_reg[23:0] * cabs[47:24];
            ahl_reg   <= a3_reg[47:24] * cabs[23:0];
            ahh_reg   <= a3_reg[47:24] * cabs[47:24];
            a4_reg    <= a3_reg;
            h4_reg    <= h3_reg;
            sh4_reg   <= sh3_reg;
            cneg4_reg <= c3_reg[PROD_W];
            zero4_reg <= (a3_reg == '0);

            hh5_reg   <= 96'(hll_reg) + (96'(hlh_reg) << 25) + (96'(hhh_reg) << 48);
            ac5_reg   <= 96'(all_reg) + ((96'(alh_reg) + 96'(ahl_reg)) << 24)
                       + (96'(ahh_reg) << 48);
            a5_reg    <= a4_reg;
            h5_reg    <= h4_reg;
            sh5_reg   <= sh4_reg;
            cneg5_reg <= cneg4_reg;
            zero5_reg <= zero4_reg;

            q6_reg          <= Q_W'(q_next);
            ray6_reg.a      <= a5_reg;
            ray6_reg.h      <= h5_reg;
            ray6_reg.shadow <= sh5_reg;
            ray6_reg.dead   <= zero5_reg || (!cneg5_reg && (ac5_reg > hh5_reg));
        end
    end

    assign out_valid = v6_reg;
    assign out_q     = q6_reg;
    assign out_ray   = ray6_reg;

endmodule

// File: hw/rtl/usri_sqrt_cell.sv
// One bit of the restoring integer square root chain.
module usri_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [usri_pkg::Q_W-1:0]         in_rem,
    input  logic [usri_pkg::SQRT_BITS-1:0]   in_root,
    input  usri_pkg::usri_ray_t              in_ray,
    output logic                             out_valid,
    output logic [usri_pkg::Q_W-1:0]         out_rem,
    output logic [usri_pkg::SQRT_BITS-1:0]   out_root,
    output usri_pkg::usri_ray_t              out_ray
);
    import usri_pkg::*;

    logic valid_reg;
    logic [Q_W-1:0] rem_reg, trial;
    logic [SQRT_BITS-1:0] root_reg;
    usri_ray_t ray_reg;
    logic fit;

    // Try this root bit against the remainder
    assign trial = (Q_W'(in_root) << (BIT + 1)) | (Q_W'(1) << (2 * BIT));
    assign fit   = (in_rem >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // Advance remainder and root
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= fit ? (in_rem - trial) : in_rem;
            root_reg <= fit ? (in_root | (SQRT_BITS'(1) << BIT)) : in_root;
            ray_reg  <= in_ray;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_ray   = ray_reg;

endmodule

// File: hw/rtl/usri_div_cell.sv
// One quotient bit of the two-lane restoring divider chain.
module usri_div_cell #(
    parameter int BIT = 0
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [usri_pkg::PROD_W-1:0]      in_a,
    input  logic [usri_pkg::REM_W-1:0]       in_rem1,
    input  logic [usri_pkg::REM_W-1:0]       in_rem2,
    input  logic [usri_pkg::DIV_BITS-1:0]    in_q1,
    input  logic [usri_pkg::DIV_BITS-1:0]    in_q2,
    input  usri_pkg::usri_hit_t              in_hit,
    output logic                             out_valid,
    output logic [usri_pkg::PROD_W-1:0]      out_a,
    output logic [usri_pkg::REM_W-1:0]       out_rem1,
    output logic [usri_pkg::REM_W-1:0]       out_rem2,
    output logic [usri_pkg::DIV_BITS-1:0]    out_q1,
    output logic [usri_pkg::DIV_BITS-1:0]    out_q2,
    output usri_pkg::usri_hit_t              out_hit
);
    import usri_pkg::*;

    logic valid_reg;
    logic [PROD_W-1:0] a_reg;
    logic [REM_W-1:0] rem1_reg, rem2_reg, dv;
    logic [DIV_BITS-1:0] q1_reg, q2_reg;
    usri_hit_t hit_reg;
    logic fit1, fit2;

    // Shifted divisor for this quotient bit
    assign dv   = REM_W'(in_a) << BIT;
    assign fit1 = (in_rem1 >= dv);
    assign fit2 = (in_rem2 >= dv);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // Subtract where the divisor fits and set the quotient bit
    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg    <= in_a;
            rem1_reg <= fit1 ? (in_rem1 - dv) : in_rem1;
            rem2_reg <= fit2 ? (in_rem2 - dv) : in_rem2;
            q1_reg   <= fit1 ? (in_q1 | (DIV_BITS'(1) << BIT)) : in_q1;
            q2_reg   <= fit2 ? (in_q2 | (DIV_BITS'(1) << BIT)) : in_q2;
            hit_reg  <= in_hit;
        end
    end

    assign out_valid = valid_reg;
    assign out_a     = a_reg;
    assign out_rem1  = rem1_reg;
    assign out_rem2  = rem2_reg;
    assign out_q1    = q1_reg;
    assign out_q2    = q2_reg;
    assign out_hit   = hit_reg;

endmodule

// File: hw/rtl/unit_sphere_ray_intersect.sv
// Ray and unit sphere intersection: a front end, a square root chain and a divider chain.
//
// Takes one ray per clock while s_tready is high (start and direction in signed
// Q8.16, shadow flag in s_tuser) and returns zero, one or two hits as signed
// Q16.16 distances, with m_tlast on the last hit of a ray. The datapath is a
// fixed pipeline: six front-end stages form the quarter discriminant, fifty
// square root cells produce one root bit each, two stages form the numerators
// and saturation flags, and thirty-one divider cells produce one quotient bit
// each for both roots at once, followed by the output register. Each ray's hits
// leave the output register one at a time, so a ray with two hits can hold the
// pipeline while its second hit is shown; rays with no hit leave no item.
module unit_sphere_ray_intersect (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // start_x, start_y, start_z, dir_x, dir_y, dir_z
    input  logic         s_tuser,   // shadow_ray
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // hit_distance
    output logic         m_tuser,   // hit_kind
    output logic         m_tlast
);
    import usri_pkg::*;

    logic pipe_en;

    // Front end
    logic      fr_valid;
    logic [Q_W-1:0] fr_q;
    usri_ray_t fr_ray;

    usri_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .in_shadow (s_tuser),
        .out_valid (fr_valid),
        .out_q     (fr_q),
        .out_ray   (fr_ray)
    );

    // Square root chain, most significant bit first
    logic                 sq_valid [0:SQRT_BITS];
    logic [Q_W-1:0]       sq_rem   [0:SQRT_BITS];
    logic [SQRT_BITS-1:0] sq_root  [0:SQRT_BITS];
    usri_ray_t            sq_ray   [0:SQRT_BITS];

    assign sq_valid[0] = fr_valid;
    assign sq_rem[0]   = fr_q;
    assign sq_root[0]  = '0;
    assign sq_ray[0]   = fr_ray;

    for (genvar j = 0; j < SQRT_BITS; j++) begin : g_sqrt
        usri_sqrt_cell #(.BIT(SQRT_BITS - 1 - j)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (sq_valid[j]),
            .in_rem    (sq_rem[j]),
            .in_root   (sq_root[j]),
            .in_ray    (sq_ray[j]),
            .out_valid (sq_valid[j+1]),
            .out_rem   (sq_rem[j+1]),
            .out_root  (sq_root[j+1]),
            .out_ray   (sq_ray[j+1])
        );
    end

    // Numerators of both roots and the hit decision
    logic signed [52:0] root_ext, h_ext, n1, n2;
    logic [1:0] cnt_next;
    logic kind_next;
    logic nv_reg;
    logic [NUM_W-1:0] n1_reg, n2_reg;
    logic [PROD_W-1:0] na_reg;
    logic [1:0] ncnt_reg;
    logic nkind_reg;

    assign root_ext = 53'(sq_root[SQRT_BITS]);
    assign h_ext    = 53'(sq_ray[SQRT_BITS].h);
    assign n1       = root_ext - h_ext;
    assign n2       = -h_ext - root_ext;

    always_comb begin
        cnt_next  = 2'd0;
        kind_next = KIND_SURFACE;
        if (sq_ray[SQRT_BITS].dead || (n1[52] && n2[52])) begin
            cnt_next = 2'd0;
        end else if (sq_ray[SQRT_BITS].shadow) begin
            cnt_next  = 2'd1;
            kind_next = KIND_SHADOW;
        end else if (!n1[52] && n2[52]) begin
            cnt_next = 2'd1;
        end else if ((n1 > 0) && (n2 > 0)) begin
            cnt_next = 2'd2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nv_reg <= 1'b0;
        end else if (pipe_en) begin
            nv_reg <= sq_valid[SQRT_BITS];
        end
    end

    // Zero the numerators that are not divided; a shadow hit divides zero
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            n1_reg    <= (n1[52] || kind_next == KIND_SHADOW) ? '0 : n1[NUM_W-1:0];
            n2_reg    <= n2[52] ? '0 : n2[NUM_W-1:0];
            na_reg    <= sq_ray[SQRT_BITS].a;
            ncnt_reg  <= cnt_next;
            nkind_reg <= kind_next;
        end
    end

    // Saturation test and divider setup
    logic                dv_valid [0:DIV_BITS];
    logic [PROD_W-1:0]   dv_a     [0:DIV_BITS];
    logic [REM_W-1:0]    dv_rem1  [0:DIV_BITS];
    logic [REM_W-1:0]    dv_rem2  [0:DIV_BITS];
    logic [DIV_BITS-1:0] dv_q1    [0:DIV_BITS];
    logic [DIV_BITS-1:0] dv_q2    [0:DIV_BITS];
    usri_hit_t           dv_hit   [0:DIV_BITS];
    logic      d0_valid_reg;
    logic [PROD_W-1:0] d0_a_reg;
    logic [REM_W-1:0] d0_rem1_reg, d0_rem2_reg;
    usri_hit_t d0_hit_reg;
    logic [62:0] sat_lim;

    assign sat_lim = 63'(na_reg) << 15;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d0_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            d0_valid_reg <= nv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            d0_a_reg        <= na_reg;
            d0_rem1_reg     <= REM_W'(n1_reg) << FRAC_W;
            d0_rem2_reg     <= REM_W'(n2_reg) << FRAC_W;
            d0_hit_reg.cnt  <= ncnt_reg;
            d0_hit_reg.kind <= nkind_reg;
            d0_hit_reg.sat1 <= (63'(n1_reg) >= sat_lim);
            d0_hit_reg.sat2 <= (63'(n2_reg) >= sat_lim);
        end
    end

    assign dv_valid[0] = d0_valid_reg;
    assign dv_a[0]     = d0_a_reg;
    assign dv_rem1[0]  = d0_rem1_reg;
    assign dv_rem2[0]  = d0_rem2_reg;
    assign dv_q1[0]    = '0;
    assign dv_q2[0]    = '0;
    assign dv_hit[0]   = d0_hit_reg;

    // Divider chain, most significant quotient bit first
    for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
        usri_div_cell #(.BIT(DIV_BITS - 1 - k)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (dv_valid[k]),
            .in_a      (dv_a[k]),
            .in_rem1   (dv_rem1[k]),
            .in_rem2   (dv_rem2[k]),
            .in_q1     (dv_q1[k]),
            .in_q2     (dv_q2[k]),
            .in_hit    (dv_hit[k]),
            .out_valid (dv_valid[k+1]),
            .out_a     (dv_a[k+1]),
            .out_rem1  (dv_rem1[k+1]),
            .out_rem2  (dv_rem2[k+1]),
            .out_q1    (dv_q1[k+1]),
            .out_q2    (dv_q2[k+1]),
            .out_hit   (dv_hit[k+1])
        );
    end

    // Output register: one ray's hits, shown one item per cycle while m_tready is high
    logic ob_valid_reg, ob_last_reg, ob_kind_reg;
    logic [T_W-1:0] ob_t_reg, ob_t2_reg;
    logic tail_valid, ob_free, ob_load, ob_pop;
    logic [T_W-1:0] t1_val, t2_val;
    usri_hit_t tail_hit;

    assign tail_valid = dv_valid[DIV_BITS];
    assign tail_hit   = dv_hit[DIV_BITS];
    assign t1_val     = tail_hit.sat1 ? T_SAT : T_W'(dv_q1[DIV_BITS]);
    assign t2_val     = tail_hit.sat2 ? T_SAT : T_W'(dv_q2[DIV_BITS]);

    assign ob_pop   = ob_valid_reg && m_tready;
    assign ob_free  = !ob_valid_reg || (m_tready && ob_last_reg);
    assign pipe_en  = !tail_valid || (tail_hit.cnt == 2'd0) || ob_free;
    assign ob_load  = pipe_en && tail_valid && (tail_hit.cnt != 2'd0);
    assign s_tready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ob_valid_reg <= 1'b0;
        end else if (ob_load) begin
            ob_valid_reg <= 1'b1;
        end else if (ob_pop && ob_last_reg) begin
            ob_valid_reg <= 1'b0;
        end
    end

    // Load a new ray's hits, or advance to the second hit
    always_ff @(posedge aclk) begin
        if (ob_load) begin
            ob_t_reg    <= t1_val;
            ob_t2_reg   <= t2_val;
            ob_kind_reg <= tail_hit.kind;
            ob_last_reg <= (tail_hit.cnt == 2'd1);
        end else if (ob_pop && !ob_last_reg) begin
            ob_t_reg    <= ob_t2_reg;
            ob_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = ob_valid_reg;
    assign m_tdata  = ob_t_reg;
    assign m_tuser  = ob_kind_reg;
    assign m_tlast  = ob_last_reg;

endmodule

// File: tb/unit_sphere_ray_intersect_tb.sv
// Self-checking testbench for the unit sphere ray intersection pipeline.
module unit_sphere_ray_intersect_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import usri_pkg::*;

    localparam int  N_RANDOM    = 700;
    localparam int  N_QUIET     = 120;
    localparam int  DRAIN_WAIT  = 200;
    localparam longint CYCLE_LIMIT = 400000;
    localparam longint ONE_Q16  = 65536;

    typedef struct {
        logic signed [COORD_W-1:0] sx, sy, sz, dx, dy, dz;
        logic                      shadow;
    } ray_t;

    typedef struct {
        logic [T_W-1:0] hit_dist;
        logic           kind;
        logic           last;
    } hit_t;

    // Predict the hits of each accepted ray and match them against the output
    class hit_scoreboard;
        hit_t   pending_hits[$];
        int     errors;

        function longint unsigned t_from_num(longint unsigned num, longint unsigned a);
            longint unsigned quo, rem;
            quo = num / a;
            rem = num % a;
            if (quo >= 64'h8000)
                return longint'(T_SAT);
            return (quo << FRAC_W) + ((rem << FRAC_W) / a);
        endfunction

        function void push_hit(longint unsigned hit_dist, logic kind, logic last);
            hit_t h;
            h.hit_dist = hit_dist[T_W-1:0];
            h.kind     = kind;
            h.last     = last;
            pending_hits.push_back(h);
        endfunction

        // Solve the half-b quadratic exactly and queue the resulting hits
        function void note_ray(ray_t r);
            longint sx, sy, sz, dx, dy, dz, a, h, c, root, n1, n2;
            logic signed [127:0] hw, aw, cw, disc, cand;
            sx = r.sx; sy = r.sy; sz = r.sz;
            dx = r.dx; dy = r.dy; dz = r.dz;
            a = dx*dx + dy*dy + dz*dz;
            h = dx*sx + dy*sy + dz*sz;
            c = sx*sx + sy*sy + sz*sz - (64'sd1 <<< 32);
            if (a == 0) return;
            hw = h; aw = a; cw = c;
            disc = hw*hw - aw*cw;
            if (disc < 0) return;
            root = 0;
            for (int b = SQRT_BITS-1; b >= 0; b--) begin
                cand = root | (64'sd1 <<< b);
                if (cand*cand <= disc) root = cand[63:0];
            end
            n1 = root - h;
            n2 = -h - root;
            if (n1 < 0 && n2 < 0) return;
            if (r.shadow) begin
                push_hit(0, KIND_SHADOW, 1'b1);
            end else if (n1 >= 0 && n2 < 0) begin
                push_hit(t_from_num(n1, a), KIND_SURFACE, 1'b1);
            end else if (n1 > 0 && n2 > 0) begin
                push_hit(t_from_num(n1, a), KIND_SURFACE, 1'b0);
                push_hit(t_from_num(n2, a), KIND_SURFACE, 1'b1);
            end
        endfunction

        function void check_hit(logic [T_W-1:0] hit_dist, logic kind, logic last);
            hit_t e;
            if (pending_hits.size() == 0) begin
                $error("unexpected hit: hit_distance=%h hit_kind=%b last_hit=%b",
                       hit_dist, kind, last);
                errors++;
                return;
            end
            e = pending_hits.pop_front();
            if (hit_dist !== e.hit_dist) begin
                $error("hit_distance: expected %h, got %h", e.hit_dist, hit_dist);
                errors++;
            end
            if (kind !== e.kind) begin
                $error("hit_kind: expected %b, got %b", e.kind, kind);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_hit: expected %b, got %b", e.last, last);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_hits.size();
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;   // start_x, start_y, start_z, dir_x, dir_y, dir_z
    logic         s_tuser;   // shadow_ray
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;   // hit_distance
    logic         m_tuser;   // hit_kind
    logic         m_tlast;

    hit_scoreboard sb;
    logic          quiet;
    longint        cycles;

    unit_sphere_ray_intersect u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Stall the result side in random bursts, never during the quiet tail
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            if (!quiet && $urandom_range(0, 2) == 0) begin
                stall = $urandom_range(1, 8);
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Check every accepted hit
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_hit(m_tdata, m_tuser, m_tlast);
    end

    // Abort on a hang
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Present one ray, hold it until accepted, then note it
    task automatic send_ray(ray_t r);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r.dz, r.dy, r.dx, r.sz, r.sy, r.sx};
        s_tuser  <= r.shadow;
        do @(posedge aclk); while (!s_tready);
        sb.note_ray(r);
    endtask

    task automatic send_q16(longint sx, longint sy, longint sz,
                            longint dx, longint dy, longint dz, logic shadow);
        ray_t r;
        r.sx = sx[23:0]; r.sy = sy[23:0]; r.sz = sz[23:0];
        r.dx = dx[23:0]; r.dy = dy[23:0]; r.dz = dz[23:0];
        r.shadow = shadow;
        send_ray(r);
    endtask

    function automatic logic signed [COORD_W-1:0] near_coord();
        return COORD_W'($signed($urandom_range(0, 6*ONE_Q16)) - 3*ONE_Q16);
    endfunction

    // Mostly rays aimed near the sphere, plus full-range noise
    task automatic send_random_ray();
        ray_t    r;
        int      mode;
        mode = $urandom_range(0, 9);
        r.sx = near_coord(); r.sy = near_coord(); r.sz = near_coord();
        if (mode < 6) begin
            // aim roughly at a point inside the sphere
            r.dx = COORD_W'($signed($urandom_range(0, ONE_Q16)) - ONE_Q16/2) - r.sx;
            r.dy = COORD_W'($signed($urandom_range(0, ONE_Q16)) - ONE_Q16/2) - r.sy;
            r.dz = COORD_W'($signed($urandom_range(0, ONE_Q16)) - ONE_Q16/2) - r.sz;
        end else if (mode < 8) begin
            r.dx = near_coord(); r.dy = near_coord(); r.dz = near_coord();
        end else begin
            r.sx = COORD_W'($urandom); r.sy = COORD_W'($urandom);
            r.sz = COORD_W'($urandom);
            r.dx = COORD_W'($urandom); r.dy = COORD_W'($urandom);
            r.dz = COORD_W'($urandom);
        end
        r.shadow = ($urandom_range(0, 4) == 0);
        send_ray(r);
    endtask

    initial begin
        sb       = new();
        quiet    = 1'b0;
        cycles   = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: two roots, one root, zero t2, both behind, miss
        send_q16(0, 0, -2*ONE_Q16, 0, 0, ONE_Q16, 1'b0);
        send_q16(0, 0, 0, 0, 0, ONE_Q16, 1'b0);
        send_q16(0, 0, ONE_Q16, 0, 0, -ONE_Q16, 1'b0);
        send_q16(0, 0, 2*ONE_Q16, 0, 0, ONE_Q16, 1'b0);
        send_q16(0, 2*ONE_Q16, 2*ONE_Q16, 0, 0, ONE_Q16, 1'b0);
        // Zero direction, inside and outside
        send_q16(0, 0, 0, 0, 0, 0, 1'b0);
        send_q16(5*ONE_Q16, 0, 0, 0, 0, 0, 1'b1);
        // Shadow hits and a shadow miss
        send_q16(0, 0, -2*ONE_Q16, 0, 0, ONE_Q16, 1'b1);
        send_q16(0, 0, 0, ONE_Q16, 0, 0, 1'b1);
        send_q16(0, 0, 2*ONE_Q16, 0, 0, ONE_Q16, 1'b1);
        // Saturating distance: tiny direction
        send_q16(0, 0, 0, 1, 0, 0, 1'b0);
        send_q16(-3*ONE_Q16, 0, 0, 1, 0, 0, 1'b0);
        // Tangent ray
        send_q16(-2*ONE_Q16, ONE_Q16, 0, ONE_Q16, 0, 0, 1'b0);
        // Field extremes
        send_q16(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 1'b0);
        send_q16(8388607, 8388607, 8388607, -8388608, -8388608, -8388608, 1'b0);
        send_q16(-8388608, 0, 0, 8388607, 0, 0, 1'b1);
        send_q16(0, 0, 0, -8388608, -8388608, -8388608, 1'b0);
        send_q16(8388607, -8388608, 0, -1, 1, -1, 1'b0);

        // Let the pipeline run dry once before the random part
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM/2) begin
                s_tvalid <= 1'b0;
                while (sb.outstanding() != 0) @(posedge aclk);
            end
            if (i == N_RANDOM - N_QUIET) quiet = 1'b1;
            send_random_ray();
        end
        s_tvalid <= 1'b0;

        // Drain, then wait out the pipeline for stray hits
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
